// ===== sv/b62_pkg.sv =====
package b62_pkg;

    // fixed field widths
    localparam int VALUE_W = 64;
    localparam int DIGIT_W = 6;
    localparam int CODE_W  = 7;
    localparam int LEN_W   = 4;

    // the value is divided as four 16-bit chunks, most significant first
    localparam int CHUNK_W  = 16;
    localparam int N_CHUNKS = VALUE_W / CHUNK_W;
    localparam int NUM_W    = DIGIT_W + CHUNK_W;

    // reciprocal of the radix: exact floor(n / 62) for every n below 62 * 2^16
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = 45;
    localparam logic [22:0] RECIP = 23'd4329605;

    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 4'd6;

    // ascii bases of the three alphabet ranges
    localparam logic [CODE_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CODE_W-1:0] ASCII_UPPER = 7'd55;
    localparam logic [CODE_W-1:0] ASCII_LOWER = 7'd61;

    typedef struct packed {
        logic [CHUNK_W-1:0] q;
        logic [DIGIT_W-1:0] r;
    } div_result_t;

    // one long-division step: ({r, chunk}) / 62 and its remainder
    function automatic div_result_t div_step(input logic [DIGIT_W-1:0] r_in,
                                             input logic [CHUNK_W-1:0] chunk);
        logic [NUM_W-1:0]   n;
        logic [PROD_W-1:0]  prod;
        logic [CHUNK_W-1:0] q;
        logic [NUM_W-1:0]   q62;
        logic [NUM_W-1:0]   rem;
        div_result_t        res;
        n    = {r_in, chunk};
        prod = PROD_W'(n) * PROD_W'(RECIP);
        q    = prod[RECIP_SHIFT +: CHUNK_W];
        // q * 62 as q * 64 - q * 2
        q62  = {q, 6'b0} - {5'b0, q, 1'b0};
        rem  = n - q62;
        res.q = q;
        res.r = rem[DIGIT_W-1:0];
        return res;
    endfunction

    // digit to ascii: 0-9, then A-Z, then a-z
    function automatic logic [CODE_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] code;
        if (d < 6'd10)
        begin
            code = ASCII_ZERO + {1'b0, d};
        end
        else if (d < 6'd36)
        begin
            code = ASCII_UPPER + {1'b0, d};
        end
        else
        begin
            code = ASCII_LOWER + {1'b0, d};
        end
        return code;
    endfunction

endpackage

// ===== sv/b62_digit_pipe.sv =====
module b62_digit_pipe #(
    parameter int MAX_DIGITS = 11
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [b62_pkg::VALUE_W-1:0]               in_value,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [MAX_DIGITS-1:0][b62_pkg::DIGIT_W-1:0] out_digits
);

    localparam int NSTG = b62_pkg::N_CHUNKS * MAX_DIGITS;

    // stage outputs and the ready chain (rdy[s] lets stage s load)
    wire                                        st_vld [NSTG];
    wire [b62_pkg::VALUE_W-1:0]                 st_v   [NSTG];
    wire [b62_pkg::DIGIT_W-1:0]                 st_r   [NSTG];
    wire [MAX_DIGITS-1:0][b62_pkg::DIGIT_W-1:0] st_dig [NSTG];
    wire [NSTG:0]                               rdy;

    assign rdy[NSTG] = out_ready;
    assign in_ready  = rdy[0];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++)
        begin : g_stage
            localparam int CH    = b62_pkg::N_CHUNKS - 1 - (s % b62_pkg::N_CHUNKS);
            localparam int DI    = s / b62_pkg::N_CHUNKS;
            localparam bit FIRST = (s % b62_pkg::N_CHUNKS) == 0;
            localparam bit LASTC = (CH == 0);

            logic                                        in_vld_w;
            logic [b62_pkg::VALUE_W-1:0]                 in_v_w;
            logic [b62_pkg::DIGIT_W-1:0]                 in_r_w;
            logic [MAX_DIGITS-1:0][b62_pkg::DIGIT_W-1:0] in_dig_w;

            logic                                        vld_reg;
            logic [b62_pkg::VALUE_W-1:0]                 v_reg;
            logic [b62_pkg::VALUE_W-1:0]                 v_next;
            logic [b62_pkg::DIGIT_W-1:0]                 r_reg;
            logic [b62_pkg::DIGIT_W-1:0]                 r_next;
            logic [MAX_DIGITS-1:0][b62_pkg::DIGIT_W-1:0] dig_reg;
            logic [MAX_DIGITS-1:0][b62_pkg::DIGIT_W-1:0] dig_next;
            b62_pkg::div_result_t                        step;

            // stage input: the port for the first stage, else the stage before
            if (s == 0)
            begin : g_first
                assign in_vld_w = in_valid;
                assign in_v_w   = in_value;
                assign in_r_w   = '0;
                assign in_dig_w = '0;
            end
            else
            begin : g_rest
                assign in_vld_w = st_vld[s-1];
                assign in_v_w   = st_v[s-1];
                assign in_r_w   = st_r[s-1];
                assign in_dig_w = st_dig[s-1];
            end

            // divide one chunk, quotient replaces it in place
            always_comb
            begin
                step     = b62_pkg::div_step(FIRST ? '0 : in_r_w,
                                             in_v_w[CH*b62_pkg::CHUNK_W +: b62_pkg::CHUNK_W]);
                v_next   = in_v_w;
                v_next[CH*b62_pkg::CHUNK_W +: b62_pkg::CHUNK_W] = step.q;
                r_next   = step.r;
                dig_next = in_dig_w;
                if (LASTC)
                begin
                    dig_next[DI] = step.r;
                end
            end

            assign rdy[s] = !vld_reg || rdy[s+1];

            // valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else if (rdy[s])
                begin
                    vld_reg <= in_vld_w;
                end
            end

            // payload
            always_ff @(posedge clk)
            begin
                if (rdy[s] && in_vld_w)
                begin
                    v_reg   <= v_next;
                    r_reg   <= r_next;
                    dig_reg <= dig_next;
                end
            end

            assign st_vld[s] = vld_reg;
            assign st_v[s]   = v_reg;
            assign st_r[s]   = r_reg;
            assign st_dig[s] = dig_reg;
        end
    endgenerate

    assign out_valid  = st_vld[NSTG-1];
    assign out_digits = st_dig[NSTG-1];

endmodule

// ===== sv/base62_id_encoder.sv =====
// Base-62 text encoder. Each 64-bit value accepted on the s_ side leaves as its base-62
// text on the m_ side, one ASCII character per transaction, most significant digit first,
// padded on the left with '0' up to min_length characters (cfg port, reset 6, 0 acts as 1,
// values above MAX_DIGITS saturate); m_tlast marks the final character. A new value may
// enter every cycle while s_tready is high; digits are found by long division over 4 * MAX_DIGITS pipeline
// stages, one 16-bit chunk divided by 62 per stage, followed by a length stage and the
// character serialiser. The sustained rate is set by the output: a value leaves as
// max(min_length, digits needed) characters, at most MAX_DIGITS (11 by default), one
// character per cycle while m_tready is high.
module base62_id_encoder #(
    parameter int MAX_DIGITS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast,   // last_char
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // min_length
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [b62_pkg::LEN_W-1:0] MAXD4 = b62_pkg::LEN_W'(MAX_DIGITS);

    logic [b62_pkg::LEN_W-1:0] min_length_reg;

    logic                                        pipe_valid;
    logic [MAX_DIGITS-1:0][b62_pkg::DIGIT_W-1:0] pipe_digits;

    logic                                        fin_vld_reg;
    logic                                        fin_rdy;
    logic [MAX_DIGITS-1:0][b62_pkg::CODE_W-1:0]  fin_codes_reg;
    logic [MAX_DIGITS-1:0][b62_pkg::CODE_W-1:0]  fin_codes_next;
    logic [IDX_W-1:0]                            fin_last_reg;
    logic [IDX_W-1:0]                            fin_last_next;
    logic [IDX_W-1:0]                            hi_idx;
    logic [IDX_W-1:0]                            min_idx;

    logic                                        busy_reg;
    logic [IDX_W-1:0]                            pos_reg;
    logic [MAX_DIGITS-1:0][b62_pkg::CODE_W-1:0]  ser_codes_reg;
    logic                                        ser_load;
    logic                                        out_xfer;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= b62_pkg::MIN_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            min_length_reg <= cfg_data;
        end
    end

    // digit extraction pipeline
    b62_digit_pipe #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata),
        .out_valid  (pipe_valid),
        .out_ready  (fin_rdy),
        .out_digits (pipe_digits)
    );

    // text length and ascii codes
    always_comb
    begin
        hi_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (pipe_digits[i] != '0)
            begin
                hi_idx = IDX_W'(i);
            end
            fin_codes_next[i] = b62_pkg::digit_to_ascii(pipe_digits[i]);
        end
        if (min_length_reg == '0)
        begin
            min_idx = '0;
        end
        else if (min_length_reg > MAXD4)
        begin
            min_idx = IDX_W'(MAX_DIGITS - 1);
        end
        else
        begin
            min_idx = IDX_W'(min_length_reg - 4'd1);
        end
        fin_last_next = (hi_idx > min_idx) ? hi_idx : min_idx;
    end

    assign out_xfer = m_tvalid && m_tready;
    assign ser_load = fin_vld_reg && (!busy_reg || (out_xfer && pos_reg == '0));
    assign fin_rdy  = !fin_vld_reg || ser_load;

    // length stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (fin_rdy)
        begin
            fin_vld_reg <= pipe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_rdy && pipe_valid)
        begin
            fin_codes_reg <= fin_codes_next;
            fin_last_reg  <= fin_last_next;
        end
    end

    // character serialiser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (ser_load)
        begin
            busy_reg <= 1'b1;
        end
        else if (out_xfer && pos_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            pos_reg       <= fin_last_reg;
            ser_codes_reg <= fin_codes_reg;
        end
        else if (out_xfer && pos_reg != '0)
        begin
            pos_reg <= pos_reg - 1'b1;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {1'b0, ser_codes_reg[pos_reg]};
    assign m_tlast  = (pos_reg == '0);

    // a shown character is always from the alphabet
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= 8'd48 && m_tdata <= 8'd122))
        else $error("character code outside the alphabet");

    // a non-final character taken moves to the next lower digit
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !m_tlast) |=> (m_tvalid && pos_reg == $past(pos_reg) - 1'b1))
        else $error("serialiser position did not step down");

    // a final character taken with nothing waiting ends the text
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && m_tlast && !fin_vld_reg) |=> !m_tvalid)
        else $error("serialiser stayed busy after the final character");

    // input held off only while the pipeline tail is occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (pipe_valid && !fin_rdy))
        else $error("input stalled with a free pipeline");

endmodule
